// ----- rtl/rstb_pkg.sv -----
// Shared constants, action codes and structs of the request slot token batcher.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package rstb_pkg;

   // table geometry
   localparam int SLOTS        = 16;
   localparam int TOKEN_BUDGET = 64;

   // fixed field widths
   localparam int ACT_W   = 2;
   localparam int ID_W    = 32;
   localparam int LEN_W   = 16;
   localparam int TIDX_W  = 6;
   localparam int SLOT_FW = 4;
   localparam int CNT_FW  = 5;
   localparam int TOK_FW  = 7;
   localparam int DEPTH_W = 17;

   // internal widths
   localparam int OFF_W   = DEPTH_W;
   localparam int LIM_W   = LEN_W + 1;
   localparam int NEXT_W  = OFF_W + 1;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int TOTAL_W = LEN_W + CNT_W;

   typedef logic [ACT_W-1:0] action_type;

   localparam action_type ACT_REGISTER  = 2'd0;
   localparam action_type ACT_ITER_DONE = 2'd1;
   localparam action_type ACT_PREPARE   = 2'd2;
   localparam action_type ACT_READ      = 2'd3;

   typedef struct packed {
      action_type          action;
      logic [ID_W-1:0]     request_id;
      logic [LEN_W-1:0]    prompt_length;
      logic [LEN_W-1:0]    generate_count;
      logic [TIDX_W-1:0]   token_index;
   } req_type;

   typedef struct packed {
      logic                busy;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    batch;
      logic [LIM_W-1:0]    limit;
      logic [ID_W-1:0]     request_id;
   } slot_type;

   // running state of one pass over the slots
   typedef struct packed {
      logic [TOTAL_W-1:0]  total;
      logic                found;
      logic                hit;
   } scan_acc_type;

   // what the slot unit reports for one slot
   typedef struct packed {
      logic                wr_en;
      slot_type            wr_data;
      logic                take;
      logic                complete;
      logic                busy_post;
      logic [TOTAL_W-1:0]  total_next;
      logic                hit;
      logic [DEPTH_W-1:0]  depth;
   } step_type;

   typedef struct packed {
      logic                accepted;
      logic [SLOT_FW-1:0]  slot_taken;
      logic [CNT_FW-1:0]   completed_count;
      logic [CNT_FW-1:0]   active_requests;
      logic [TOK_FW-1:0]   active_tokens;
      logic                map_overflow;
      logic                entry_valid;
      logic [SLOT_FW-1:0]  entry_slot;
      logic [DEPTH_W-1:0]  entry_depth;
      logic [ID_W-1:0]     entry_request_id;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/rstb_if.sv -----
// Valid/ready channel interfaces of the request slot token batcher.
// Depends on rstb_pkg for field widths.
`default_nettype none

interface rstb_req_if;
   logic                          valid;
   logic                          ready;
   logic [rstb_pkg::ACT_W-1:0]    action;
   logic [rstb_pkg::ID_W-1:0]     request_id;
   logic [rstb_pkg::LEN_W-1:0]    prompt_length;
   logic [rstb_pkg::LEN_W-1:0]    generate_count;
   logic [rstb_pkg::TIDX_W-1:0]   token_index;

   modport source (output valid, action, request_id, prompt_length, generate_count,
                   token_index, input ready);
   modport sink   (input valid, action, request_id, prompt_length, generate_count,
                   token_index, output ready);
endinterface

interface rstb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [rstb_pkg::SLOT_FW-1:0]  slot_taken;
   logic [rstb_pkg::CNT_FW-1:0]   completed_count;
   logic [rstb_pkg::CNT_FW-1:0]   active_requests;
   logic [rstb_pkg::TOK_FW-1:0]   active_tokens;
   logic                          map_overflow;
   logic                          entry_valid;
   logic [rstb_pkg::SLOT_FW-1:0]  entry_slot;
   logic [rstb_pkg::DEPTH_W-1:0]  entry_depth;
   logic [rstb_pkg::ID_W-1:0]     entry_request_id;

   modport source (output valid, accepted, slot_taken, completed_count, active_requests,
                   active_tokens, map_overflow, entry_valid, entry_slot, entry_depth,
                   entry_request_id, input ready);
   modport sink   (input valid, accepted, slot_taken, completed_count, active_requests,
                   active_tokens, map_overflow, entry_valid, entry_slot, entry_depth,
                   entry_request_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/rstb_slot_table.sv -----
// Slot register file: busy bits plus offset, batch, limit and id per slot.
// Depends on rstb_pkg. One read/write index per cycle.
`default_nettype none

module rstb_slot_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rstb_pkg::SLOT_W-1:0] idx,
   input  logic                       wr_en,
   input  rstb_pkg::slot_type         wr_data,
   output rstb_pkg::slot_type         rd_data
);
   import rstb_pkg::*;

   logic [SLOTS-1:0]   busy_ff;
   logic [OFF_W-1:0]   offset_ff [SLOTS];
   logic [LEN_W-1:0]   batch_ff  [SLOTS];
   logic [LIM_W-1:0]   limit_ff  [SLOTS];
   logic [ID_W-1:0]    id_ff     [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (wr_en) begin
         busy_ff[idx] <= wr_data.busy;
      end
   end

   // payload only matters behind a busy bit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         offset_ff[idx] <= wr_data.offset;
         batch_ff[idx]  <= wr_data.batch;
         limit_ff[idx]  <= wr_data.limit;
         id_ff[idx]     <= wr_data.request_id;
      end
   end

   always_comb begin
      rd_data.busy       = busy_ff[idx];
      rd_data.offset     = offset_ff[idx];
      rd_data.batch      = batch_ff[idx];
      rd_data.limit      = limit_ff[idx];
      rd_data.request_id = id_ff[idx];
   end

endmodule

`default_nettype wire

// ----- rtl/rstb_slot_alu.sv -----
// Shared slot unit: applies the current action to one slot and advances the
// running token total and token lookup. Depends on rstb_pkg.
`default_nettype none

module rstb_slot_alu (
   input  rstb_pkg::req_type       req,
   input  rstb_pkg::slot_type      cur,
   input  rstb_pkg::scan_acc_type  acc,
   output rstb_pkg::step_type      step
);
   import rstb_pkg::*;

   logic [NEXT_W-1:0]   next_off;
   logic [TOTAL_W-1:0]  sum_cur;
   logic [TOTAL_W-1:0]  sum_post;
   logic [TOTAL_W-1:0]  idx_ext;
   logic [TOTAL_W-1:0]  rel;
   slot_type            post;
   logic                wr_en;
   logic                take;
   logic                complete;

   always_comb begin
      next_off = NEXT_W'(cur.offset) + NEXT_W'(cur.batch);
      sum_cur  = acc.total + TOTAL_W'(cur.batch);
      post     = cur;
      wr_en    = 1'b0;
      take     = 1'b0;
      complete = 1'b0;

      case (req.action)
         ACT_REGISTER: begin
            if (!cur.busy && !acc.found) begin
               post.busy       = 1'b1;
               post.offset     = '0;
               post.batch      = req.prompt_length;
               post.limit      = LIM_W'(req.prompt_length) + LIM_W'(req.generate_count);
               post.request_id = req.request_id;
               wr_en           = 1'b1;
               take            = 1'b1;
            end
         end
         ACT_ITER_DONE: begin
            if (cur.busy) begin
               wr_en = 1'b1;
               if (next_off >= NEXT_W'(cur.limit)) begin
                  post.busy   = 1'b0;
                  post.offset = '0;
                  post.batch  = '0;
                  complete    = 1'b1;
               end else begin
                  post.offset = OFF_W'(next_off);
                  post.batch  = LEN_W'(1);
               end
            end
         end
         ACT_PREPARE: begin
            // running total never exceeds the budget during this pass
            if (cur.busy && sum_cur > TOTAL_W'(TOKEN_BUDGET)) begin
               wr_en      = 1'b1;
               post.batch = LEN_W'(TOTAL_W'(TOKEN_BUDGET) - acc.total);
            end
         end
         default: begin
         end
      endcase

      sum_post = acc.total + TOTAL_W'(post.batch);
      idx_ext  = TOTAL_W'(req.token_index);
      rel      = idx_ext - acc.total;

      step.wr_en      = wr_en;
      step.wr_data    = post;
      step.take       = take;
      step.complete   = complete;
      step.busy_post  = post.busy;
      step.total_next = post.busy ? sum_post : acc.total;
      step.hit        = (req.action == ACT_READ) && post.busy && !acc.hit &&
                        (idx_ext < sum_post);
      step.depth      = post.offset + DEPTH_W'(rel);
   end

endmodule

`default_nettype wire

// ----- rtl/request_slot_token_batcher.sv -----
// Top level of the request slot token batcher: sequencer, scan accumulators and
// response register. Depends on rstb_pkg, rstb_if, rstb_slot_table, rstb_slot_alu.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    action, request_id, prompt_length,
//                                  generate_count, token_index
//   rsp_ch    out   valid/ready    accepted .. entry_request_id (one per request)
//
// Each request makes one pass over the slot table after its transfer, one slot
// per cycle through the shared slot unit, then loads the response register.
// Ready returns the cycle after the load, so a new request is not taken until
// the previous one has loaded its response. The table's single port sets this
// pace. Reset frees every slot; no clearing pass is needed.
// A stalled response holds in its register while the next request is taken;
// a finished pass waits only if that register is still full.
`default_nettype none

module request_slot_token_batcher (
   input  logic       clock,
   input  logic       reset,
   rstb_req_if.sink   req_ch,
   rstb_rsp_if.source rsp_ch
);
   import rstb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // sequencer
   logic [1:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;

   // latched request and pass accumulators
   req_type             req_ff, req_in;
   scan_acc_type        acc_ff, acc_in;
   logic [CNT_W-1:0]    busy_cnt_ff, busy_cnt_in;
   logic [CNT_W-1:0]    done_cnt_ff, done_cnt_in;
   logic [SLOT_W-1:0]   taken_ff, taken_in;
   logic [SLOT_W-1:0]   eslot_ff, eslot_in;
   logic [DEPTH_W-1:0]  edepth_ff, edepth_in;
   logic [ID_W-1:0]     eid_ff, eid_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                rsp_load;
   logic                over;

   slot_type            slot_rd;
   step_type            step;
   logic                tbl_wr;

   rstb_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .idx     (idx_ff),
      .wr_en   (tbl_wr),
      .wr_data (step.wr_data),
      .rd_data (slot_rd)
   );

   rstb_slot_alu u_alu (
      .req  (req_ff),
      .cur  (slot_rd),
      .acc  (acc_ff),
      .step (step)
   );

   assign tbl_wr       = (state_ff == ST_SCAN) && step.wr_en;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_in      = req_ff;
      acc_in      = acc_ff;
      busy_cnt_in = busy_cnt_ff;
      done_cnt_in = done_cnt_ff;
      taken_in    = taken_ff;
      eslot_in    = eslot_ff;
      edepth_in   = edepth_ff;
      eid_in      = eid_ff;
      rsp_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in              = ST_SCAN;
               idx_in                = '0;
               req_in.action         = req_ch.action;
               req_in.request_id     = req_ch.request_id;
               req_in.prompt_length  = req_ch.prompt_length;
               req_in.generate_count = req_ch.generate_count;
               req_in.token_index    = req_ch.token_index;
               acc_in                = '0;
               busy_cnt_in           = '0;
               done_cnt_in           = '0;
               taken_in              = '0;
               eslot_in              = '0;
               edepth_in             = '0;
               eid_in                = '0;
            end
         end
         ST_SCAN: begin
            // slot idx_ff: action update and map summary in one step
            acc_in.total = step.total_next;
            busy_cnt_in  = busy_cnt_ff + CNT_W'(step.busy_post);
            done_cnt_in  = done_cnt_ff + CNT_W'(step.complete);
            if (step.take) begin
               acc_in.found = 1'b1;
               taken_in     = idx_ff;
            end
            if (step.hit) begin
               acc_in.hit = 1'b1;
               eslot_in   = idx_ff;
               edepth_in  = step.depth;
               eid_in     = slot_rd.request_id;
            end
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in = SLOT_W'(idx_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // map size saturates at the budget; overflow flags the excess
   always_comb begin
      over                         = acc_ff.total > TOTAL_W'(TOKEN_BUDGET);
      rsp_data_in.accepted         = acc_ff.found;
      rsp_data_in.slot_taken       = SLOT_FW'(taken_ff);
      rsp_data_in.completed_count  = CNT_FW'(done_cnt_ff);
      rsp_data_in.active_requests  = CNT_FW'(busy_cnt_ff);
      rsp_data_in.active_tokens    = over ? TOK_FW'(TOKEN_BUDGET) : TOK_FW'(acc_ff.total);
      rsp_data_in.map_overflow     = over;
      rsp_data_in.entry_valid      = acc_ff.hit;
      rsp_data_in.entry_slot       = SLOT_FW'(eslot_ff);
      rsp_data_in.entry_depth      = edepth_ff;
      rsp_data_in.entry_request_id = eid_ff;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      busy_cnt_ff <= busy_cnt_in;
      done_cnt_ff <= done_cnt_in;
      taken_ff    <= taken_in;
      eslot_ff    <= eslot_in;
      edepth_ff   <= edepth_in;
      eid_ff      <= eid_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.accepted         = rsp_data_ff.accepted;
   assign rsp_ch.slot_taken       = rsp_data_ff.slot_taken;
   assign rsp_ch.completed_count  = rsp_data_ff.completed_count;
   assign rsp_ch.active_requests  = rsp_data_ff.active_requests;
   assign rsp_ch.active_tokens    = rsp_data_ff.active_tokens;
   assign rsp_ch.map_overflow     = rsp_data_ff.map_overflow;
   assign rsp_ch.entry_valid      = rsp_data_ff.entry_valid;
   assign rsp_ch.entry_slot       = rsp_data_ff.entry_slot;
   assign rsp_ch.entry_depth      = rsp_data_ff.entry_depth;
   assign rsp_ch.entry_request_id = rsp_data_ff.entry_request_id;

   // a transfer in always starts a pass at slot zero
   a_pass_start: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("pass did not start at slot zero");

   // a response appears only at the end of a pass
   a_rsp_after_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside pass end");

   // register and iteration done never report in the same response
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.accepted && rsp_data_ff.completed_count != '0))
      else $error("register and completion reported together");

   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.active_requests <= CNT_FW'(SLOTS))
      else $error("busy count above slot count");

   // a token found means the map is not empty
   a_entry_in_map: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.entry_valid) |-> rsp_data_ff.active_tokens != '0)
      else $error("token entry reported with empty map");

endmodule

`default_nettype wire
